// ----- hw/rtl/aac_pkg.sv -----
// Shared types and codes for the ARP address cache.
// Used by aac_cell and arp_address_cache; depends on nothing else.
`timescale 1ns / 1ps

package aac_pkg;

    localparam int IP_W  = 32;
    localparam int MAC_W = 48;
    localparam int AGE_W = 16;

    typedef logic [1:0] t_func;

    localparam t_func FUNC_TICK     = 2'd0;
    localparam t_func FUNC_UPDATE   = 2'd1;
    localparam t_func FUNC_FIND_IP  = 2'd2;
    localparam t_func FUNC_FIND_MAC = 2'd3;

    localparam logic [AGE_W-1:0] AGE_MAX = {AGE_W{1'b1}};

    // One table entry as held in a cell.
    typedef struct packed {
        logic [IP_W-1:0]  ip;
        logic [MAC_W-1:0] mac;
        logic [AGE_W-1:0] age;
    } t_entry;

    // The request that walks down the row of cells, collecting its answer.
    typedef struct packed {
        logic             valid;
        t_func            func;
        logic [IP_W-1:0]  ip;
        logic [MAC_W-1:0] mac;
        logic             create;
        logic             hit;
        logic             appended;
        logic             found;
        logic             resolved;
        logic             pending;
        logic [MAC_W-1:0] out_mac;
        logic [IP_W-1:0]  out_ip;
    } t_probe;

endpackage

// ----- hw/rtl/aac_cell.sv -----
// One slot of the ARP table: holds an entry, serves the request passing by,
// and swaps with its neighbors while the table closes up after aging.
// Depends on aac_pkg.
`timescale 1ns / 1ps

module aac_cell #(
    parameter int DEPTH = 16,
    parameter int IDX   = 0
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic [$clog2(DEPTH+1)-1:0]   i_count,
    input  logic [aac_pkg::AGE_W-1:0]    i_age_limit,
    input  aac_pkg::t_probe              i_probe,
    input  logic [$clog2(DEPTH+1)-1:0]   i_alive,
    input  logic                         i_compact,
    input  logic                         i_phase,
    input  aac_pkg::t_entry              i_right,
    input  logic                         i_right_dead,
    input  logic                         i_left_dead,
    output aac_pkg::t_probe              o_probe,
    output logic [$clog2(DEPTH+1)-1:0]   o_alive,
    output aac_pkg::t_entry              o_entry,
    output logic                         o_dead
);

    localparam int CNT_W = $clog2(DEPTH+1);
    localparam logic IDX_ODD = 1'(IDX % 2);

    aac_pkg::t_entry   r_entry, n_entry;
    logic              r_dead, n_dead;
    aac_pkg::t_probe   r_probe, n_probe;
    logic [CNT_W-1:0]  r_alive, n_alive;

    logic                     w_occupied;
    logic                     w_at_tail;
    logic [aac_pkg::AGE_W-1:0] w_age;

    assign w_occupied = CNT_W'(IDX) < i_count;
    assign w_at_tail  = CNT_W'(IDX) == i_count;
    assign w_age      = (r_entry.age == aac_pkg::AGE_MAX) ? r_entry.age
                                                          : r_entry.age + aac_pkg::AGE_W'(1);

    always_comb begin
        n_entry = r_entry;
        n_dead  = r_dead;
        n_probe = i_probe;
        n_alive = i_alive;
        if (i_compact) begin
            // Odd-even transposition: a dead slot trades places with a live
            // right neighbor, which keeps the live entries in order.
            if (IDX_ODD == i_phase) begin
                if (r_dead && !i_right_dead) begin
                    n_entry = i_right;
                    n_dead  = 1'b0;
                end
            end else begin
                if (i_left_dead && !r_dead) begin
                    n_dead = 1'b1;
                end
            end
        end else if (i_probe.valid) begin
            case (i_probe.func)
                aac_pkg::FUNC_TICK: begin
                    if (w_occupied) begin
                        n_entry.age = w_age;
                        n_dead      = w_age > i_age_limit;
                        if (w_age <= i_age_limit) begin
                            n_alive = i_alive + CNT_W'(1);
                        end
                    end else begin
                        n_dead = 1'b1;
                    end
                end
                aac_pkg::FUNC_UPDATE: begin
                    if (w_occupied && !i_probe.hit && i_probe.ip != '0 &&
                        r_entry.ip == i_probe.ip) begin
                        n_entry.mac      = i_probe.mac;
                        n_entry.age      = '0;
                        n_probe.hit      = 1'b1;
                        n_probe.resolved = i_probe.mac != '0;
                    end else if (w_at_tail && !i_probe.hit && i_probe.create) begin
                        // Every occupied slot lies upstream, so a miss is final here.
                        n_entry.ip       = i_probe.ip;
                        n_entry.mac      = i_probe.mac;
                        n_entry.age      = '0;
                        n_probe.hit      = 1'b1;
                        n_probe.appended = 1'b1;
                        n_probe.pending  = i_probe.mac == '0;
                    end
                end
                aac_pkg::FUNC_FIND_IP: begin
                    if (w_occupied && !i_probe.hit && i_probe.ip != '0 &&
                        r_entry.ip == i_probe.ip) begin
                        n_probe.hit = 1'b1;
                        if (r_entry.mac != '0) begin
                            n_probe.found   = 1'b1;
                            n_probe.out_mac = r_entry.mac;
                        end
                    end
                end
                default: begin
                    if (w_occupied && !i_probe.hit && i_probe.mac != '0 &&
                        r_entry.mac == i_probe.mac) begin
                        n_probe.hit    = 1'b1;
                        n_probe.found  = 1'b1;
                        n_probe.out_ip = r_entry.ip;
                    end
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        r_entry <= n_entry;
        r_dead  <= n_dead;
        r_alive <= n_alive;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_probe.valid <= 1'b0;
        end else begin
            r_probe <= n_probe;
        end
    end

    assign o_probe = r_probe;
    assign o_alive = r_alive;
    assign o_entry = r_entry;
    assign o_dead  = r_dead;

endmodule

// ----- hw/rtl/arp_address_cache.sv -----
// Top level of the ARP address cache: stream ports, request sequencing and
// the row of aac_cell slots. Depends on aac_pkg and aac_cell.
//
//   channel   direction  signals                      contents
//   s_axis    in         tvalid tready tdata tuser    request item
//   m_axis    out        tvalid tready tdata          answer item
//   age cfg   in         i_age_limit_we i_age_limit   age limit register
//
// A request walks the row one slot per cycle on its way from acceptance to
// the output register. A tick then closes up the table with DEPTH rounds of
// neighbor swaps. One item is in the row at a time; the next is taken while
// an answer waits. Reset is synchronous and empties the table; no clearing
// pass is needed.
`timescale 1ns / 1ps

module arp_address_cache #(
    parameter int DEPTH = 16
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      s_axis_tvalid,
    output logic                      s_axis_tready,
    // [31:0] ip_addr, [79:32] mac_addr, [80] create_if_absent, [87:81] zero
    input  logic [87:0]               s_axis_tdata,
    // [1:0] func
    input  logic [1:0]                s_axis_tuser,
    output logic                      m_axis_tvalid,
    input  logic                      m_axis_tready,
    // [0] found, [48:1] mac_out, [80:49] ip_out, [81] resolved,
    // [82] pending_created, [83] dropped_full, [87:84] zero
    output logic [87:0]               m_axis_tdata,
    input  logic                      i_age_limit_we,
    input  logic [aac_pkg::AGE_W-1:0] i_age_limit
);

    localparam int CNT_W  = $clog2(DEPTH+1);
    localparam int STEP_W = $clog2(DEPTH);

    localparam logic [1:0] S_IDLE    = 2'd0;
    localparam logic [1:0] S_RUN     = 2'd1;
    localparam logic [1:0] S_COMPACT = 2'd2;
    localparam logic [1:0] S_HOLD    = 2'd3;

    logic [1:0]                r_state;
    logic [CNT_W-1:0]          r_count;
    logic [STEP_W-1:0]         r_step;
    logic [aac_pkg::AGE_W-1:0] r_age_limit;
    aac_pkg::t_probe           r_launch;
    logic [83:0]               r_res;
    logic                      r_m_valid;
    logic [87:0]               r_m_data;

    aac_pkg::t_probe  w_probe [DEPTH+1];
    logic [CNT_W-1:0] w_alive [DEPTH+1];
    aac_pkg::t_entry  w_entry [DEPTH];
    logic             w_dead  [DEPTH];
    logic [DEPTH:0]   w_busy;

    aac_pkg::t_probe w_last;
    logic            w_accept;
    logic            w_out_free;
    logic            w_dropped;

    assign s_axis_tready = r_state == S_IDLE;
    assign w_accept      = s_axis_tvalid && s_axis_tready;
    assign w_out_free    = !r_m_valid || m_axis_tready;
    assign w_last        = w_probe[DEPTH];
    assign w_dropped     = w_last.func == aac_pkg::FUNC_UPDATE && w_last.create &&
                           !w_last.hit;

    assign w_probe[0] = r_launch;
    assign w_alive[0] = '0;

    genvar g;
    generate
        for (g = 0; g < DEPTH; g++) begin : g_cell
            aac_pkg::t_entry w_right;
            logic            w_right_dead;
            logic            w_left_dead;
            if (g < DEPTH - 1) begin : g_mid
                assign w_right      = w_entry[g+1];
                assign w_right_dead = w_dead[g+1];
            end else begin : g_end
                assign w_right      = '0;
                assign w_right_dead = 1'b1;
            end
            if (g > 0) begin : g_left
                assign w_left_dead = w_dead[g-1];
            end else begin : g_first
                assign w_left_dead = 1'b0;
            end

            aac_cell #(
                .DEPTH (DEPTH),
                .IDX   (g)
            ) u_cell (
                .i_clk        (i_clk),
                .i_rst_n      (i_rst_n),
                .i_count      (r_count),
                .i_age_limit  (r_age_limit),
                .i_probe      (w_probe[g]),
                .i_alive      (w_alive[g]),
                .i_compact    (r_state == S_COMPACT),
                .i_phase      (r_step[0]),
                .i_right      (w_right),
                .i_right_dead (w_right_dead),
                .i_left_dead  (w_left_dead),
                .o_probe      (w_probe[g+1]),
                .o_alive      (w_alive[g+1]),
                .o_entry      (w_entry[g]),
                .o_dead       (w_dead[g])
            );
        end
        for (g = 0; g <= DEPTH; g++) begin : g_busy
            assign w_busy[g] = w_probe[g].valid;
        end
    endgenerate

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_age_limit <= aac_pkg::AGE_W'(60);
        end else if (i_age_limit_we) begin
            r_age_limit <= i_age_limit;
        end
    end

    always_ff @(posedge i_clk) begin
        r_launch.func     <= s_axis_tuser;
        r_launch.ip       <= s_axis_tdata[31:0];
        r_launch.mac      <= s_axis_tdata[79:32];
        r_launch.create   <= s_axis_tdata[80];
        r_launch.hit      <= 1'b0;
        r_launch.appended <= 1'b0;
        r_launch.found    <= 1'b0;
        r_launch.resolved <= 1'b0;
        r_launch.pending  <= 1'b0;
        r_launch.out_mac  <= '0;
        r_launch.out_ip   <= '0;
        if (!i_rst_n) begin
            r_launch.valid <= 1'b0;
        end else begin
            r_launch.valid <= w_accept;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_RUN && w_last.valid) begin
            r_res <= {w_dropped, w_last.pending, w_last.resolved,
                      w_last.out_ip, w_last.out_mac, w_last.found};
        end
        if (r_state == S_HOLD && w_out_free) begin
            r_m_data <= {4'b0, r_res};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_count   <= '0;
            r_step    <= '0;
            r_m_valid <= 1'b0;
        end else begin
            if (r_state == S_HOLD && w_out_free) begin
                r_m_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_m_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_state <= S_RUN;
                    end
                end
                S_RUN: begin
                    if (w_last.valid) begin
                        if (w_last.func == aac_pkg::FUNC_TICK) begin
                            r_count <= w_alive[DEPTH];
                            r_step  <= '0;
                            r_state <= S_COMPACT;
                        end else begin
                            if (w_last.appended) begin
                                r_count <= r_count + CNT_W'(1);
                            end
                            r_state <= S_HOLD;
                        end
                    end
                end
                S_COMPACT: begin
                    r_step <= r_step + STEP_W'(1);
                    if (r_step == STEP_W'(DEPTH - 1)) begin
                        r_state <= S_HOLD;
                    end
                end
                S_HOLD: begin
                    if (w_out_free) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = r_m_data;

    // The table never holds more entries than it has slots.
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(DEPTH))
        else $error("entry count above table depth");

    // At most one request travels the row at a time.
    a_one_probe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0(w_busy))
        else $error("more than one request in the row");

    // The input side only opens with the row empty.
    a_ready_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tready |-> w_busy == '0)
        else $error("ready while a request is in the row");

    // Compaction runs exactly its rounds and then hands over the answer.
    a_compact_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_COMPACT && r_step == STEP_W'(DEPTH - 1)) |=> r_state == S_HOLD)
        else $error("compaction did not finish on time");

    // An answer only reaches the output after the request left the row.
    a_load_after: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_m_valid) |-> $past(r_state) == S_HOLD)
        else $error("answer loaded outside the hold state");

endmodule
